>>> rtl/rbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_pkg
// Shared types, codes and helpers of the ROM/RAM bank mapper with clock.
// ----------------------------------------------------------------------------
package rbm_pkg;

    // Operation codes of an input word
    localparam logic [1:0] OP_READ  = 2'd0;
    localparam logic [1:0] OP_WRITE = 2'd1;
    localparam logic [1:0] OP_TICK  = 2'd2;

    // Target codes of a result word
    localparam logic [2:0] TGT_NONE  = 3'd0;
    localparam logic [2:0] TGT_ROM   = 3'd1;
    localparam logic [2:0] TGT_RAM   = 3'd2;
    localparam logic [2:0] TGT_CLOCK = 3'd3;
    localparam logic [2:0] TGT_OPEN  = 3'd4;
    localparam logic [2:0] TGT_UNSUP = 3'd5;

    // Clock register banks
    localparam logic [3:0] BANK_SECONDS = 4'h8;
    localparam logic [3:0] BANK_MINUTES = 4'h9;
    localparam logic [3:0] BANK_HOURS   = 4'hA;
    localparam logic [3:0] BANK_DAYS    = 4'hB;
    localparam logic [3:0] BANK_FLAGS   = 4'hC;

    localparam logic [7:0] OPEN_BUS = 8'hFF;

    // External RAM banks fitted; banks 0..7 mirror modulo this count
    localparam int         RAM_BANK_COUNT = 8;
    localparam logic [3:0] RAM_CNT        = 4'(RAM_BANK_COUNT);

    typedef struct packed {
        logic [7:0] days;
        logic [4:0] hours;
        logic [5:0] minutes;
        logic [5:0] seconds;
    } rtc_time_t;

    // Register updates requested by one decoded word
    typedef struct packed {
        logic tick;
        logic latch_write;
        logic enable_write;
        logic rom_write;
        logic bank_write;
    } rbm_ctrl_t;

    typedef struct packed {
        logic [2:0]  target;
        logic [20:0] mapped_address;
        logic        write_strobe;
        logic [7:0]  read_data;
    } rbm_result_t;

    // bank mod RAM_BANK_COUNT by repeated subtraction (3-bit value)
    function automatic logic [2:0] ram_bank_wrap(input logic [2:0] bank);
        logic [3:0] v;
        v = {1'b0, bank};
        for (int i = 0; i < 8; i++)
        begin
            if (v >= RAM_CNT)
            begin
                v = v - RAM_CNT;
            end
        end
        return v[2:0];
    endfunction

endpackage
`default_nettype wire

>>> rtl/rbm_word_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_word_if
// Valid/ready channels for bus words in and mapped results out.
// ----------------------------------------------------------------------------
interface rbm_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  operation;
    logic [15:0] address;
    logic [7:0]  write_data;

    modport source (output valid, output operation, output address,
                    output write_data, input ready);
    modport sink   (input valid, input operation, input address,
                    input write_data, output ready);
endinterface

interface rbm_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  target;
    logic [20:0] mapped_address;
    logic        write_strobe;
    logic [7:0]  read_data;

    modport source (output valid, output target, output mapped_address,
                    output write_strobe, output read_data, input ready);
    modport sink   (input valid, input target, input mapped_address,
                    input write_strobe, input read_data, output ready);
endinterface
`default_nettype wire

>>> rtl/rbm_rtc.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_rtc
// Live clock counters with 60/60/24 ripple, latch sequence and latched copy.
// ----------------------------------------------------------------------------
module rbm_rtc
    import rbm_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       tick,
    input  wire logic       latch_write,
    input  wire logic [7:0] latch_byte,
    output rtc_time_t       latched
);

    rtc_time_t  live_reg, live_next;
    rtc_time_t  latched_reg;
    logic [7:0] last_latch_byte_reg;
    logic       latch_fire;

    // Any field at or above its limit carries
    always_comb
    begin
        live_next = live_reg;
        live_next.seconds = live_reg.seconds + 6'd1;
        if (live_next.seconds >= 6'd60)
        begin
            live_next.seconds = '0;
            live_next.minutes = live_reg.minutes + 6'd1;
            if (live_next.minutes >= 6'd60)
            begin
                live_next.minutes = '0;
                live_next.hours = live_reg.hours + 5'd1;
                if (live_next.hours >= 5'd24)
                begin
                    live_next.hours = '0;
                    live_next.days = live_reg.days + 8'd1;
                end
            end
        end
    end

    assign latch_fire = latch_write && (last_latch_byte_reg == 8'd0) && (latch_byte == 8'd1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            live_reg            <= '0;
            latched_reg         <= '0;
            last_latch_byte_reg <= '0;
        end
        else
        begin
            if (tick)
            begin
                live_reg <= live_next;
            end
            if (latch_fire)
            begin
                latched_reg <= live_reg;
            end
            if (latch_write)
            begin
                last_latch_byte_reg <= latch_byte;
            end
        end
    end

    assign latched = latched_reg;

endmodule
`default_nettype wire

>>> rtl/rbm_decode.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rbm_decode
// Address decode and bank translation of one bus word.
// ----------------------------------------------------------------------------
module rbm_decode
    import rbm_pkg::*;
#(
    parameter int ROM_BANK_BITS = 7
)
(
    input  wire logic [1:0]               operation,
    input  wire logic [15:0]              address,
    input  wire logic                     ram_enable,
    input  wire logic [3:0]               ram_bank,
    input  wire logic [ROM_BANK_BITS-1:0] rom_sel,
    input  wire logic [6:0]               rom_mask,
    input  wire rtc_time_t                latched,
    output rbm_ctrl_t                     ctrl,
    output rbm_result_t                   res
);

    // Control register windows below 0x8000, by address[14:13]
    localparam logic [1:0] WIN_ENABLE = 2'd0;
    localparam logic [1:0] WIN_ROM    = 2'd1;
    localparam logic [1:0] WIN_BANK   = 2'd2;

    logic                     is_write;
    logic [ROM_BANK_BITS-1:0] rom_eff;

    always_comb
    begin
        rom_eff = rom_sel & rom_mask[ROM_BANK_BITS-1:0];
        if (rom_eff == '0)
        begin
            rom_eff = ROM_BANK_BITS'(1);
        end
    end

    assign is_write = (operation == OP_WRITE);

    always_comb
    begin
        ctrl = '0;
        res  = '0;
        case (operation)
            OP_TICK:
            begin
                ctrl.tick = 1'b1;
            end
            OP_READ, OP_WRITE:
            begin
                if (!address[15])
                begin
                    if (is_write)
                    begin
                        case (address[14:13])
                            WIN_ENABLE: ctrl.enable_write = 1'b1;
                            WIN_ROM:    ctrl.rom_write    = 1'b1;
                            WIN_BANK:   ctrl.bank_write   = 1'b1;
                            default:    ctrl.latch_write  = 1'b1;
                        endcase
                    end
                    else if (!address[14])
                    begin
                        res.target         = TGT_ROM;
                        res.mapped_address = 21'(address[13:0]);
                    end
                    else
                    begin
                        res.target         = TGT_ROM;
                        res.mapped_address = {7'(rom_eff), address[13:0]};
                    end
                end
                else if (address inside {[16'hA000:16'hBFFF]})
                begin
                    if (!ram_enable)
                    begin
                        res.target    = TGT_OPEN;
                        res.read_data = is_write ? 8'd0 : OPEN_BUS;
                    end
                    else if (!ram_bank[3])
                    begin
                        res.target         = TGT_RAM;
                        res.mapped_address = 21'({ram_bank_wrap(ram_bank[2:0]),
                                                  address[12:0]});
                        res.write_strobe   = is_write;
                    end
                    else if (ram_bank inside {[BANK_SECONDS:BANK_FLAGS]} && !is_write)
                    begin
                        res.target = TGT_CLOCK;
                        case (ram_bank)
                            BANK_SECONDS: res.read_data = 8'(latched.seconds);
                            BANK_MINUTES: res.read_data = 8'(latched.minutes);
                            BANK_HOURS:   res.read_data = 8'(latched.hours);
                            BANK_DAYS:    res.read_data = latched.days;
                            default:      res.read_data = 8'd0;
                        endcase
                    end
                    else
                    begin
                        res.target = TGT_UNSUP;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule
`default_nettype wire

>>> rtl/rom_ram_bank_mapper_rtc_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rom_ram_bank_mapper_rtc_unit
// Cartridge ROM/RAM bank mapper with RTC, one word per cycle unless stalled.
// ----------------------------------------------------------------------------
// Takes one word per clock (bus read, bus write or one-second tick) while the
// output is not stalled, and returns exactly one result word for each, in
// order. The word is captured in the input register, decoded there, and
// applied to the bank/clock registers as its result is registered in the
// output register. Throughput is one word per cycle as long as the sink takes
// results; in_word.ready follows out_word.ready combinationally, so a stall on
// the output backs up at most the two stages.
// Control writes below 0x8000 update the mapper as the word retires, so a
// following access sees the new bank. rom_bank_mask is written through
// cfg_wr_en/cfg_wr_data; the user must do so only while idle, as the block
// does not enforce it. Reset value is 127.
// ----------------------------------------------------------------------------
module rom_ram_bank_mapper_rtc_unit
    import rbm_pkg::*;
#(
    parameter int ROM_BANK_BITS = 7
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_wr_en,
    input  wire logic [6:0] cfg_wr_data,
    rbm_in_if.sink          in_word,
    rbm_out_if.source       out_word
);

    // configuration
    logic [6:0] rom_bank_mask_reg;

    // mapper registers
    logic                     ram_enable_reg;
    logic [ROM_BANK_BITS-1:0] rom_bank_reg;
    logic [3:0]               ram_bank_reg;

    // input stage
    logic        s1_valid_reg, s1_valid_next;
    logic [1:0]  s1_operation_reg;
    logic [15:0] s1_address_reg;
    logic [7:0]  s1_write_data_reg;

    // output stage
    logic        out_valid_reg, out_valid_next;
    rbm_result_t out_reg;

    logic        in_accept;
    logic        out_free;
    logic        s1_advance;
    rbm_ctrl_t   ctrl;
    rbm_result_t res;
    rtc_time_t   latched;

    // Output slot frees when empty or being taken this cycle
    assign out_free   = !out_valid_reg || out_word.ready;
    assign s1_advance = s1_valid_reg && out_free;
    assign in_word.ready = !s1_valid_reg || out_free;
    assign in_accept  = in_word.valid && in_word.ready;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        if (s1_advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_word.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    rbm_decode #(
        .ROM_BANK_BITS (ROM_BANK_BITS)
    ) u_decode (
        .operation  (s1_operation_reg),
        .address    (s1_address_reg),
        .ram_enable (ram_enable_reg),
        .ram_bank   (ram_bank_reg),
        .rom_sel    (rom_bank_reg),
        .rom_mask   (rom_bank_mask_reg),
        .latched    (latched),
        .ctrl       (ctrl),
        .res        (res)
    );

    // Clock state moves only when the decoded word retires
    rbm_rtc u_rtc (
        .clk         (clk),
        .rst_n       (rst_n),
        .tick        (s1_advance && ctrl.tick),
        .latch_write (s1_advance && ctrl.latch_write),
        .latch_byte  (s1_write_data_reg),
        .latched     (latched)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rom_bank_mask_reg <= 7'h7F;
            ram_enable_reg    <= 1'b0;
            rom_bank_reg      <= ROM_BANK_BITS'(1);
            ram_bank_reg      <= '0;
            s1_valid_reg      <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            s1_valid_reg  <= s1_valid_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en)
            begin
                rom_bank_mask_reg <= cfg_wr_data;
            end
            if (s1_advance)
            begin
                if (ctrl.enable_write)
                begin
                    ram_enable_reg <= (s1_write_data_reg[3:0] == 4'hA);
                end
                if (ctrl.rom_write)
                begin
                    rom_bank_reg <= s1_write_data_reg[ROM_BANK_BITS-1:0];
                end
                if (ctrl.bank_write)
                begin
                    ram_bank_reg <= s1_write_data_reg[3:0];
                end
            end
        end
    end

    // Payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_operation_reg  <= in_word.operation;
            s1_address_reg    <= in_word.address;
            s1_write_data_reg <= in_word.write_data;
        end
        if (s1_advance)
        begin
            out_reg <= res;
        end
    end

    assign out_word.valid          = out_valid_reg;
    assign out_word.target         = out_reg.target;
    assign out_word.mapped_address = out_reg.mapped_address;
    assign out_word.write_strobe   = out_reg.write_strobe;
    assign out_word.read_data      = out_reg.read_data;

endmodule
`default_nettype wire
